/* rtl/core/ghtc_pkg.sv */
// ----------------------------------------------------------------------------
// ghtc_pkg : shared types and constants for the gravity height/tilt block
// Word layouts of both channels, pipeline carry types and fixed-point limits.
// ----------------------------------------------------------------------------
package ghtc_pkg;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [15:0] down_axis_x;
    logic signed [15:0] down_axis_y;
    logic signed [15:0] down_axis_z;
  } in_word_t;

  typedef struct packed {
    logic        [30:0] height;
    logic        [14:0] coupling;
    logic signed [31:0] jacobian_x;
    logic signed [31:0] jacobian_y;
    logic signed [31:0] jacobian_z;
    logic               gravity_valid;
  } out_word_t;

  // Running sums handed along the chain of cells.
  typedef struct packed {
    logic signed [65:0] along;
    logic signed [49:0] dot;
  } acc_t;

  // Products formed by one cell, added in by the next.
  typedef struct packed {
    logic signed [63:0] along;
    logic signed [47:0] dot;
  } prd_t;

  // Normalised gravity and derived Jacobian handed to the datapath.
  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic signed [31:0] jx;
    logic signed [31:0] jy;
    logic signed [31:0] jz;
    logic               valid;
    logic               busy;
  } grav_t;

  typedef enum logic [2:0] {
    N_START,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIVIDE,
    N_JACOB,
    N_IDLE
  } norm_state_t;

  localparam logic [1:0] REG_GRAVITY_X  = 2'd0;
  localparam logic [1:0] REG_GRAVITY_Y  = 2'd1;
  localparam logic [1:0] REG_GRAVITY_Z  = 2'd2;
  localparam logic [1:0] REG_JAC_SCALE  = 2'd3;

  localparam logic signed [31:0] SCALE_RESET   = 32'sd65536;
  localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;
  localparam logic        [30:0] HEIGHT_FLOOR  = 31'd1311;
  localparam logic        [30:0] HEIGHT_MAX    = 31'h7FFF_FFFF;
  localparam logic        [14:0] COUPLING_FLOOR = 15'd819;
  localparam logic        [14:0] COUPLING_MAX  = 15'h7FFF;
  localparam logic         [7:0] MIN_SQ_SUM    = 8'd43;

endpackage

/* rtl/core/ghtc_in_if.sv */
// ----------------------------------------------------------------------------
// ghtc_in_if : input channel
// Valid/ready channel carrying one position and down-axis word.
// ----------------------------------------------------------------------------
interface ghtc_in_if;
  logic               valid;
  logic               ready;
  ghtc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ghtc_out_if.sv */
// ----------------------------------------------------------------------------
// ghtc_out_if : result channel
// Valid/ready channel carrying one height, coupling and Jacobian word.
// ----------------------------------------------------------------------------
interface ghtc_out_if;
  logic                valid;
  logic                ready;
  ghtc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ghtc_norm.sv */
// ----------------------------------------------------------------------------
// ghtc_norm : configuration registers and gravity normaliser
// Holds the registers and, after reset and after each write, derives the Q2.30
// unit vector (shift, square, bit-serial root, restoring divide) and the Jacobian.
// ----------------------------------------------------------------------------
module ghtc_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  output ghtc_pkg::grav_t    grav
);

  ghtc_pkg::norm_state_t state_r, state_nxt;

  logic signed [31:0] gx_r, gy_r, gz_r, scale_r;
  logic        [31:0] a_r [3];
  logic               neg_r [3];
  logic        [31:0] mx_r;
  logic         [5:0] cnt_r;
  logic         [1:0] ci_r;
  logic        [63:0] sum_r;
  logic        [63:0] n_r, res_r, bit_r;
  logic        [32:0] rem_r;
  logic        [30:0] q_r;
  logic signed [31:0] u_r [3];
  logic signed [31:0] j_r [3];
  logic signed [63:0] prod_r;
  logic               valid_r;

  logic        [31:0] abs_g [3];
  logic        [31:0] mx_g;
  logic               tiny_g;
  logic         [7:0] tiny_sum;
  logic        [63:0] sq;
  logic        [63:0] sum_all;
  logic        [63:0] rb;
  logic        [32:0] trial;
  logic               qbit;
  logic        [30:0] q_all;
  logic signed [63:0] neg_prod;
  logic signed [33:0] flo;
  logic signed [31:0] jsat;
  logic               busy;

  always_comb begin
    abs_g[0] = gx_r[31] ? 32'(-gx_r) : 32'(gx_r);
    abs_g[1] = gy_r[31] ? 32'(-gy_r) : 32'(gy_r);
    abs_g[2] = gz_r[31] ? 32'(-gz_r) : 32'(gz_r);
    mx_g = abs_g[0];
    if (abs_g[1] > mx_g) begin
      mx_g = abs_g[1];
    end
    if (abs_g[2] > mx_g) begin
      mx_g = abs_g[2];
    end
    // Only components below seven can give a square sum under the limit.
    tiny_g = (abs_g[0] < 32'd7) && (abs_g[1] < 32'd7) && (abs_g[2] < 32'd7);
    tiny_sum = 8'(abs_g[0][2:0] * abs_g[0][2:0]) + 8'(abs_g[1][2:0] * abs_g[1][2:0])
             + 8'(abs_g[2][2:0] * abs_g[2][2:0]);
  end

  always_comb begin
    sq      = (cnt_r[1:0] <= 2'd2) ? a_r[cnt_r[1:0]] * a_r[cnt_r[1:0]] : 64'd0;
    sum_all = sum_r + sq;
    rb      = res_r + bit_r;
    trial   = {rem_r[31:0], (cnt_r == 6'd0) ? a_r[ci_r][0] : 1'b0};
    qbit    = trial >= {1'b0, res_r[31:0]};
    q_all   = {q_r[29:0], qbit};
    neg_prod = -prod_r;
    flo      = 34'(neg_prod >>> 30);
    if (flo > 34'sd2147483647) begin
      jsat = 32'sh7FFF_FFFF;
    end else if (flo < -34'sd2147483648) begin
      jsat = 32'sh8000_0000;
    end else begin
      jsat = 32'(flo);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    priority if (cfg_we) begin
      state_nxt = ghtc_pkg::N_START;
    end else begin
      unique case (state_r)
        ghtc_pkg::N_START: begin
          state_nxt = (tiny_g && tiny_sum < ghtc_pkg::MIN_SQ_SUM) ?
                      ghtc_pkg::N_JACOB : ghtc_pkg::N_SHIFT;
        end
        ghtc_pkg::N_SHIFT: begin
          if (mx_r[31:30] != 2'b00) begin
            state_nxt = ghtc_pkg::N_SQUARE;
          end
        end
        ghtc_pkg::N_SQUARE: begin
          if (cnt_r == 6'd2) begin
            state_nxt = ghtc_pkg::N_ROOT;
          end
        end
        ghtc_pkg::N_ROOT: begin
          if (cnt_r == 6'd31) begin
            state_nxt = ghtc_pkg::N_DIVIDE;
          end
        end
        ghtc_pkg::N_DIVIDE: begin
          if (cnt_r == 6'd30 && ci_r == 2'd2) begin
            state_nxt = ghtc_pkg::N_JACOB;
          end
        end
        ghtc_pkg::N_JACOB: begin
          if (cnt_r == 6'd3) begin
            state_nxt = ghtc_pkg::N_IDLE;
          end
        end
        ghtc_pkg::N_IDLE: state_nxt = ghtc_pkg::N_IDLE;
        default:          state_nxt = ghtc_pkg::N_START;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    busy       = (state_r != ghtc_pkg::N_IDLE);
    grav.ux    = u_r[0];
    grav.uy    = u_r[1];
    grav.uz    = u_r[2];
    grav.jx    = j_r[0];
    grav.jy    = j_r[1];
    grav.jz    = j_r[2];
    grav.valid = valid_r;
    grav.busy  = busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ghtc_pkg::N_START;
      gx_r    <= '0;
      gy_r    <= '0;
      gz_r    <= '0;
      scale_r <= ghtc_pkg::SCALE_RESET;
      cnt_r   <= '0;
      ci_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          ghtc_pkg::REG_GRAVITY_X: gx_r    <= cfg_data;
          ghtc_pkg::REG_GRAVITY_Y: gy_r    <= cfg_data;
          ghtc_pkg::REG_GRAVITY_Z: gz_r    <= cfg_data;
          ghtc_pkg::REG_JAC_SCALE: scale_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ghtc_pkg::N_START: begin
          cnt_r <= '0;
          ci_r  <= '0;
        end
        ghtc_pkg::N_SQUARE: begin
          cnt_r <= (cnt_r == 6'd2) ? 6'd0 : cnt_r + 6'd1;
        end
        ghtc_pkg::N_ROOT: begin
          cnt_r <= (cnt_r == 6'd31) ? 6'd0 : cnt_r + 6'd1;
        end
        ghtc_pkg::N_DIVIDE: begin
          if (cnt_r == 6'd30) begin
            cnt_r <= '0;
            ci_r  <= (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ghtc_pkg::N_JACOB: begin
          cnt_r <= cnt_r + 6'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ghtc_pkg::N_START: begin
        sum_r <= '0;
        if (tiny_g && tiny_sum < ghtc_pkg::MIN_SQ_SUM) begin
          valid_r <= 1'b0;
          u_r[0]  <= '0;
          u_r[1]  <= '0;
          u_r[2]  <= ghtc_pkg::ONE_Q30;
        end else begin
          valid_r  <= 1'b1;
          a_r[0]   <= abs_g[0];
          a_r[1]   <= abs_g[1];
          a_r[2]   <= abs_g[2];
          neg_r[0] <= gx_r[31];
          neg_r[1] <= gy_r[31];
          neg_r[2] <= gz_r[31];
          mx_r     <= mx_g;
        end
      end
      ghtc_pkg::N_SHIFT: begin
        if (mx_r[31:30] == 2'b00) begin
          a_r[0] <= a_r[0] << 1;
          a_r[1] <= a_r[1] << 1;
          a_r[2] <= a_r[2] << 1;
          mx_r   <= mx_r << 1;
        end
      end
      ghtc_pkg::N_SQUARE: begin
        sum_r <= sum_all;
        if (cnt_r == 6'd2) begin
          n_r   <= sum_all;
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      ghtc_pkg::N_ROOT: begin
        if (n_r >= rb) begin
          n_r   <= n_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        rem_r <= {2'b00, a_r[0][31:1]};
      end
      ghtc_pkg::N_DIVIDE: begin
        q_r <= q_all;
        if (cnt_r == 6'd30 && ci_r != 2'd2) begin
          rem_r <= {2'b00, a_r[ci_r + 2'd1][31:1]};
        end else begin
          rem_r <= qbit ? trial - {1'b0, res_r[31:0]} : trial;
        end
        if (cnt_r == 6'd30) begin
          u_r[ci_r] <= neg_r[ci_r] ? -$signed({1'b0, q_all}) : $signed({1'b0, q_all});
        end
      end
      ghtc_pkg::N_JACOB: begin
        if (cnt_r[1:0] != 2'd3) begin
          prod_r <= u_r[cnt_r[1:0]] * scale_r;
        end
        if (cnt_r[1:0] != 2'd0) begin
          j_r[cnt_r[1:0] - 2'd1] <= jsat;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/ghtc_cell.sv */
// ----------------------------------------------------------------------------
// ghtc_cell : one cell of the projection chain
// Adds the neighbour's products into the running sums and forms its own
// component products for the next cell.
// ----------------------------------------------------------------------------
module ghtc_cell (
  input  logic               clk,
  input  logic               en,
  input  ghtc_pkg::in_word_t item_in,
  input  ghtc_pkg::acc_t     acc_in,
  input  ghtc_pkg::prd_t     prd_in,
  input  logic signed [31:0] pos,
  input  logic signed [15:0] dax,
  input  logic signed [31:0] u,
  output ghtc_pkg::in_word_t item_r,
  output ghtc_pkg::acc_t     acc_r,
  output ghtc_pkg::prd_t     prd_r
);

  logic signed [63:0] p_along;
  logic signed [47:0] p_dot;

  always_comb begin
    p_along = 64'(pos) * 64'(u);
    p_dot   = 48'(dax) * 48'(u);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r    <= item_in;
      acc_r.along <= $signed(acc_in.along) + 66'($signed(prd_in.along));
      acc_r.dot   <= $signed(acc_in.dot) + 50'($signed(prd_in.dot));
      prd_r.along <= p_along;
      prd_r.dot   <= p_dot;
    end
  end

endmodule

/* rtl/core/ghtc_finish.sv */
// ----------------------------------------------------------------------------
// ghtc_finish : output stage
// Closes the sums, clamps height and coupling and registers the result word.
// ----------------------------------------------------------------------------
module ghtc_finish (
  input  logic                clk,
  input  logic                en,
  input  ghtc_pkg::acc_t      acc_in,
  input  ghtc_pkg::prd_t      prd_in,
  input  ghtc_pkg::grav_t     grav,
  output ghtc_pkg::out_word_t word_r
);

  logic signed [66:0] neg_along;
  logic signed [36:0] h_full;
  logic signed [49:0] dot;
  logic        [49:0] dot_abs;
  logic        [19:0] c_full;
  logic        [30:0] height;
  logic        [14:0] coupling;

  always_comb begin
    neg_along = -(67'($signed(acc_in.along)) + 67'($signed(prd_in.along)));
    h_full    = 37'(neg_along >>> 30);
    if (neg_along < ($signed(67'(ghtc_pkg::HEIGHT_FLOOR)) <<< 30)) begin
      height = ghtc_pkg::HEIGHT_FLOOR;
    end else if (h_full > $signed(37'(ghtc_pkg::HEIGHT_MAX))) begin
      height = ghtc_pkg::HEIGHT_MAX;
    end else begin
      height = h_full[30:0];
    end
    dot     = $signed(acc_in.dot) + 50'($signed(prd_in.dot));
    dot_abs = dot[49] ? 50'(-dot) : 50'(dot);
    c_full  = dot_abs[49:30];
    if (c_full < 20'(ghtc_pkg::COUPLING_FLOOR)) begin
      coupling = ghtc_pkg::COUPLING_FLOOR;
    end else if (c_full > 20'(ghtc_pkg::COUPLING_MAX)) begin
      coupling = ghtc_pkg::COUPLING_MAX;
    end else begin
      coupling = c_full[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.height        <= height;
      word_r.coupling      <= coupling;
      word_r.jacobian_x    <= grav.jx;
      word_r.jacobian_y    <= grav.jy;
      word_r.jacobian_z    <= grav.jz;
      word_r.gravity_valid <= grav.valid;
    end
  end

endmodule

/* rtl/core/gravity_height_and_tilt_coupling.sv */
// ----------------------------------------------------------------------------
// gravity_height_and_tilt_coupling : height and tilt coupling along gravity
// Projects each position and down axis on the configured unit gravity.
// ----------------------------------------------------------------------------
// Usage: write gravity x/y/z and the Jacobian scale through the cfg port
// (index 0 to 3). Each write starts the normaliser, which derives the unit
// gravity and Jacobian in a start step, the shift steps, three squares, 32
// root steps, 93 divide steps and the Jacobian steps, or in the start and
// Jacobian steps alone when the +Z fallback applies; in_ready stays low
// meanwhile. The same happens once after reset, which restores zero gravity
// and a scale of one.
// Each input word gives one result word. A word passes three registered chain
// cells and the registered output stage before its result is offered, and one
// word per cycle is taken while the receiver is ready and the normaliser idle.
// When the receiver stalls the output word holds; empty stages still fill,
// so words are accepted until every stage is occupied.
// ----------------------------------------------------------------------------
module gravity_height_and_tilt_coupling (
  input  logic        clk,
  input  logic        rst_n,
  ghtc_in_if.sink     in_chan,
  ghtc_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  ghtc_pkg::grav_t    grav;
  ghtc_pkg::in_word_t item [4];
  ghtc_pkg::acc_t     acc  [4];
  ghtc_pkg::prd_t     prd  [4];
  logic         [2:0] vld_r;
  logic               out_vld_r;
  logic         [3:0] en;
  logic               in_take;

  ghtc_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .grav     (grav)
  );

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[3] = !out_vld_r || out_chan.ready;
    en[2] = !vld_r[2] || en[3];
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
    in_chan.ready = en[0] && !grav.busy && !cfg_we;
    in_take = in_chan.valid && in_chan.ready;
  end

  always_comb begin
    item[0] = in_chan.data;
    acc[0]  = '0;
    prd[0]  = '0;
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    ghtc_cell u_cell (
      .clk     (clk),
      .en      (en[k]),
      .item_in (item[k]),
      .acc_in  (acc[k]),
      .prd_in  (prd[k]),
      .pos     ((k == 0) ? item[k].position_x :
                (k == 1) ? item[k].position_y : item[k].position_z),
      .dax     ((k == 0) ? item[k].down_axis_x :
                (k == 1) ? item[k].down_axis_y : item[k].down_axis_z),
      .u       ((k == 0) ? grav.ux : (k == 1) ? grav.uy : grav.uz),
      .item_r  (item[k+1]),
      .acc_r   (acc[k+1]),
      .prd_r   (prd[k+1])
    );
  end

  ghtc_finish u_finish (
    .clk    (clk),
    .en     (en[3]),
    .acc_in (acc[3]),
    .prd_in (prd[3]),
    .grav   (grav),
    .word_r (out_chan.data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_take;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) out_vld_r <= vld_r[2];
    end
  end

  assign out_chan.valid = out_vld_r;

  a_no_take_busy : assert property (@(posedge clk) disable iff (!rst_n)
    grav.busy |-> !in_take)
    else $error("word accepted while normaliser busy");

  a_cfg_starts : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> grav.busy)
    else $error("configuration write did not restart normaliser");

  a_floors : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.data.height >= ghtc_pkg::HEIGHT_FLOOR &&
                        out_chan.data.coupling >= ghtc_pkg::COUPLING_FLOOR))
    else $error("result below floor");

  a_fallback : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.data.gravity_valid) |->
      (out_chan.data.jacobian_x == 32'sd0 && out_chan.data.jacobian_y == 32'sd0))
    else $error("fallback Jacobian not along z");

endmodule

/* test/ghtc_tb_if.sv */
// ----------------------------------------------------------------------------
// ghtc_tb_if : testbench channel interfaces
// The block's own channel interfaces are used; this file holds no extra logic.
// ----------------------------------------------------------------------------
package ghtc_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  localparam int unsigned LIMIT_CYCLES = 400000;
endpackage

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench : gravity height and tilt coupling
// Drives position and down-axis words under several gravity and scale
// settings, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  ghtc_in_if  in_chan ();
  ghtc_out_if out_chan ();

  gravity_height_and_tilt_coupling DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  logic signed [31:0]  grav_reg [3];
  logic signed [31:0]  scale_reg;
  ghtc_pkg::out_word_t expected_words [$];
  int unsigned         mismatches = 0;
  int unsigned         words_seen = 0;
  int unsigned         cycles = 0;
  bit                  sink_bursty;
  bit                  src_bursty;
  bit                  long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > ghtc_tb_pkg::LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit gravity in Q2.30, with the +Z fallback when the magnitude is tiny.
  task automatic unit_gravity(output logic signed [63:0] u [3], output bit ok);
    logic signed [63:0] g [3];
    logic [63:0] s, m, a, mag;
    int k;
    s = 0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      g[i] = grav_reg[i];
      a = g[i] < 0 ? -g[i] : g[i];
      s += a * a;
      if (a > m) m = a;
    end
    ok = s >= 64'd43;
    if (!ok) begin
      u[0] = 0;
      u[1] = 0;
      u[2] = 64'sd1 << 30;
    end else begin
      k = 0;
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        k++;
      end
      s = 0;
      for (int i = 0; i < 3; i++) begin
        g[i] = g[i] <<< k;
        a = g[i] < 0 ? -g[i] : g[i];
        s += a * a;
      end
      mag = int_sqrt(s);
      for (int i = 0; i < 3; i++) u[i] = (g[i] * (64'sd1 <<< 30)) / $signed(mag);
    end
  endtask

  function automatic ghtc_pkg::out_word_t height_and_coupling(ghtc_pkg::in_word_t w,
                                                              logic signed [63:0] u [3],
                                                              bit ok);
    ghtc_pkg::out_word_t r;
    logic signed [95:0] along, prod;
    logic signed [63:0] dot;
    logic signed [95:0] h;
    logic [63:0] c;
    along = 0;
    dot = 0;
    along += 96'(w.position_x) * 96'(u[0]);
    along += 96'(w.position_y) * 96'(u[1]);
    along += 96'(w.position_z) * 96'(u[2]);
    dot += 64'(w.down_axis_x) * u[0];
    dot += 64'(w.down_axis_y) * u[1];
    dot += 64'(w.down_axis_z) * u[2];
    along = -along;
    if (along < (96'sd1311 <<< 30)) h = 1311;
    else begin
      h = along >>> 30;
      if (h > 96'sd2147483647) h = 96'sd2147483647;
    end
    c = (dot < 0 ? -dot : dot) >> 30;
    if (c < 64'd819) c = 819;
    if (c > 64'd32767) c = 32767;
    r.height = h[30:0];
    r.coupling = c[14:0];
    for (int i = 0; i < 3; i++) begin
      prod = -(96'(u[i]) * 96'(scale_reg));
      prod = prod >>> 30;  // arithmetic shift floors toward minus infinity
      if (prod > 96'sd2147483647) prod = 96'sd2147483647;
      if (prod < -96'sd2147483648) prod = -96'sd2147483648;
      case (i)
        0: r.jacobian_x = prod[31:0];
        1: r.jacobian_y = prod[31:0];
        default: r.jacobian_z = prod[31:0];
      endcase
    end
    r.gravity_valid = ok;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s at word %0d: got %0h, want %0h", what, words_seen, got, want);
    mismatches++;
  endtask

  // Result checker and receiver-side stalls.
  int hold_left;
  always @(posedge clk) begin
    ghtc_pkg::out_word_t e;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_chan.data.height), 64'd0);
        end else begin
          e = expected_words.pop_front();
          if (out_chan.data.height !== e.height)
            report_mismatch("height", 64'(out_chan.data.height), 64'(e.height));
          if (out_chan.data.coupling !== e.coupling)
            report_mismatch("coupling", 64'(out_chan.data.coupling), 64'(e.coupling));
          if (out_chan.data.jacobian_x !== e.jacobian_x)
            report_mismatch("jacobian_x", 64'(out_chan.data.jacobian_x), 64'(e.jacobian_x));
          if (out_chan.data.jacobian_y !== e.jacobian_y)
            report_mismatch("jacobian_y", 64'(out_chan.data.jacobian_y), 64'(e.jacobian_y));
          if (out_chan.data.jacobian_z !== e.jacobian_z)
            report_mismatch("jacobian_z", 64'(out_chan.data.jacobian_z), 64'(e.jacobian_z));
          if (out_chan.data.gravity_valid !== e.gravity_valid)
            report_mismatch("gravity_valid", 64'(out_chan.data.gravity_valid),
                            64'(e.gravity_valid));
        end
      end
      if (long_hold) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_chan.ready <= (hold_left == 1);
      end else if (sink_bursty && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(1, 14);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ghtc_pkg::REG_GRAVITY_X: grav_reg[0] = val;
      ghtc_pkg::REG_GRAVITY_Y: grav_reg[1] = val;
      ghtc_pkg::REG_GRAVITY_Z: grav_reg[2] = val;
      ghtc_pkg::REG_JAC_SCALE: scale_reg = val;
    endcase
  endtask

  // Waits for the pipeline to drain before the configuration changes.
  task automatic settle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_gravity(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                             logic [31:0] sc);
    settle();
    write_reg(ghtc_pkg::REG_GRAVITY_X, gx);
    write_reg(ghtc_pkg::REG_GRAVITY_Y, gy);
    write_reg(ghtc_pkg::REG_GRAVITY_Z, gz);
    write_reg(ghtc_pkg::REG_JAC_SCALE, sc);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(ghtc_pkg::in_word_t w);
    logic signed [63:0] u [3];
    bit ok;
    int gap;
    if (src_bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    unit_gravity(u, ok);
    expected_words.push_back(height_and_coupling(w, u, ok));
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
    endcase
  endfunction

  function automatic ghtc_pkg::in_word_t rand_word();
    ghtc_pkg::in_word_t w;
    w.position_x = rand_pos();
    w.position_y = rand_pos();
    w.position_z = rand_pos();
    w.down_axis_x = rand_axis();
    w.down_axis_y = rand_axis();
    w.down_axis_z = rand_axis();
    return w;
  endfunction

  function automatic logic [31:0] rand_grav();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 12)) - 6);
      default: return 32'($signed($urandom_range(0, 1400000)) - 700000);
    endcase
  endfunction

  task automatic test_reset_gravity();
    ghtc_pkg::in_word_t w;
    w = '0;
    send_word(w);
    w.position_z = -32'sd655360;
    w.down_axis_z = 16'sd16384;
    send_word(w);
  endtask

  task automatic test_directed_extremes();
    ghtc_pkg::in_word_t w;
    set_gravity(32'h0, 32'h0, -32'sd642252, 32'sd65536);
    w = '0;
    w.position_z = 32'h7FFF_FFFF; w.down_axis_z = -16'sd16384;
    send_word(w);
    w.position_z = 32'h8000_0000; w.down_axis_z = 16'h7FFF;
    send_word(w);
    w.position_z = 32'sd1311; w.down_axis_z = 16'h8000;
    send_word(w);
    w = '1;
    send_word(w);
    in_chan.valid <= 1'b0;
    // Tiny gravity that falls back to +Z, and one just at the threshold.
    set_gravity(32'sd3, 32'sd3, 32'sd4, 32'h8000_0000);
    send_word(rand_word());
    in_chan.valid <= 1'b0;
    set_gravity(32'sd3, 32'sd3, 32'sd5, 32'h7FFF_FFFF);
    send_word(rand_word());
    in_chan.valid <= 1'b0;
    set_gravity(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    w.position_x = 32'h8000_0000; w.position_y = 32'h8000_0000;
    w.position_z = 32'h8000_0000;
    w.down_axis_x = 16'sd16384; w.down_axis_y = 16'sd16384; w.down_axis_z = 16'sd16384;
    send_word(w);
    send_word(rand_word());
    in_chan.valid <= 1'b0;
    set_gravity(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_word(rand_word());
    send_word(rand_word());
    in_chan.valid <= 1'b0;
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      set_gravity(rand_grav(), rand_grav(), rand_grav(),
                  $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 200000)));
      src_bursty = 1'b1;
      sink_bursty = 1'b1;
      for (int n = 0; n < 45; n++) send_word(rand_word());
      in_chan.valid <= 1'b0;
    end
  endtask

  task automatic test_backpressure();
    int held;
    set_gravity(32'sd40000, -32'sd300000, -32'sd600000, 32'sd131072);
    src_bursty = 1'b0;
    long_hold = 1'b1;
    fork
      begin
        held = 0;
        while (held < 60) begin
          @(posedge clk);
          held++;
        end
        long_hold = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_word(rand_word());
    join
    in_chan.valid <= 1'b0;
  endtask

  task automatic test_steady_stream();
    set_gravity(rand_grav(), rand_grav(), -32'sd642252, $urandom);
    src_bursty = 1'b0;
    sink_bursty = 1'b0;
    for (int n = 0; n < 80; n++) send_word(rand_word());
    in_chan.valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    grav_reg[0] = 0; grav_reg[1] = 0; grav_reg[2] = 0;
    scale_reg = ghtc_pkg::SCALE_RESET;
    sink_bursty = 1'b0;
    src_bursty = 1'b0;
    long_hold = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_gravity();
    in_chan.valid <= 1'b0;
    test_directed_extremes();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d result words over reset, extreme and random gravity settings,",
             words_seen);
    $display("with random idling on both sides and one long receiver stall.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* gravity_height_and_tilt_coupling.f */
rtl/core/ghtc_pkg.sv
rtl/core/ghtc_in_if.sv
rtl/core/ghtc_out_if.sv
rtl/core/ghtc_norm.sv
rtl/core/ghtc_cell.sv
rtl/core/ghtc_finish.sv
rtl/core/gravity_height_and_tilt_coupling.sv
test/ghtc_tb_if.sv
test/testbench.sv
